// ===== src/mbf_pkg.sv =====
// Shared types, constants and helpers for the mip level box filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mbf_pkg;

    localparam int LOG_MAX_SIZE = 8;
    localparam int LOG_W        = 4;
    localparam int LEV_W        = $clog2(LOG_MAX_SIZE);
    localparam int COORD_W      = LOG_MAX_SIZE;
    localparam int OUT_COORD_W  = LOG_MAX_SIZE - 1;
    localparam int ROW_SLOTS    = 1 << LOG_MAX_SIZE;
    localparam int ROW_DEPTH    = ROW_SLOTS - 1;
    localparam int ADDR_W       = $clog2(ROW_DEPTH);
    localparam int CHAN_W       = 8;
    localparam int PAIR_W       = CHAN_W + 1;
    localparam int TOTAL_W      = CHAN_W + 2;
    localparam int NUM_CHAN     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = LOG_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIPMAP_ENABLE = 2'd2;

    // Channel order: 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
    typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_t;

    typedef struct packed {
        pixel_t               pix;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [LOG_W-1:0]     lw;
        logic [LOG_W-1:0]     lh;
        logic                 en;
    } item_t;

    typedef struct packed {
        logic [LOG_W-1:0]       level;
        logic [OUT_COORD_W-1:0] x;
        logic [OUT_COORD_W-1:0] y;
        pixel_t                 pix;
        logic                   last;
    } result_t;

    function automatic logic [LOG_W-1:0] clamp_log(input logic [LOG_W-1:0] v);
        clamp_log = (v > LOG_W'(LOG_MAX_SIZE)) ? LOG_W'(LOG_MAX_SIZE) : v;
    endfunction

    // First row-store entry of destination level lev+1
    function automatic logic [ADDR_W-1:0] row_base(input logic [LEV_W-1:0] lev);
        logic [ADDR_W:0] slots;
        slots    = (ADDR_W+1)'(ROW_SLOTS);
        row_base = ADDR_W'(slots - (slots >> lev));
    endfunction

endpackage

// ===== src/mbf_pix_if.sv =====
// Pixel input channel: valid/ready handshake with one RGBA8 base pixel.
// Depends on mbf_pkg for the channel width.
`timescale 1ns / 1ps

interface mbf_pix_if;
    import mbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== src/mbf_res_if.sv =====
// Result channel: valid/ready handshake with one mip pixel and its position.
// Depends on mbf_pkg for the field widths.
`timescale 1ns / 1ps

interface mbf_res_if;
    import mbf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LOG_W-1:0]       level;
    logic [OUT_COORD_W-1:0] out_x;
    logic [OUT_COORD_W-1:0] out_y;
    logic [CHAN_W-1:0]      out_red;
    logic [CHAN_W-1:0]      out_green;
    logic [CHAN_W-1:0]      out_blue;
    logic [CHAN_W-1:0]      out_alpha;
    logic                   last_of_run;

    modport source (output valid, level, out_x, out_y, out_red, out_green, out_blue,
                    out_alpha, last_of_run, input ready);
    modport sink   (input valid, level, out_x, out_y, out_red, out_green, out_blue,
                    out_alpha, last_of_run, output ready);
endinterface

// ===== src/mbf_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on mbf_pkg for the index and data widths.
`timescale 1ns / 1ps

interface mbf_cfg_if;
    import mbf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mbf_engine.sv =====
// Level sequencer with the row pair-sum memory and the pending left pixels.
// Depends on mbf_pkg for item and result types.
`timescale 1ns / 1ps

module mbf_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  mbf_pkg::item_t   item,
    output logic             item_ready,
    input  logic             res_space,
    output logic             res_valid,
    output mbf_pkg::result_t res
);
    import mbf_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_H, ST_V} state_t;

    // Row pair-sum memory: one write or one read per cycle, registered read
    pair_t  row_mem [0:ROW_DEPTH-1];
    pixel_t pend_mem [0:LOG_MAX_SIZE-1];

    state_t             state_reg, state_next;
    logic [LEV_W-1:0]   lev_reg, lev_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] xn_reg, xn_next;
    logic [LOG_W-1:0]   wl_reg, wl_next;
    logic [LOG_W-1:0]   hl_reg, hl_next;
    pixel_t             px_reg, px_next;
    pair_t              pair_reg, pair_next;
    pair_t              rd_data_reg;

    logic               pend_we, mem_we, mem_re, done, load;
    pixel_t             pend_rd;
    pair_t              pair_c;
    logic [COORD_W-1:0] xn_c;
    logic [ADDR_W:0]    idx_sum;
    logic [ADDR_W-1:0]  idx;
    logic [TOTAL_W-1:0] total;
    pixel_t             px_new;
    logic [COORD_W-1:0] y_new;
    logic [LOG_W-1:0]   wl_new, hl_new;
    logic               last;
    logic               run_end;

    assign pend_rd = pend_mem[lev_reg];

    // Horizontal pair and memory address for the current level
    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (wl_reg == '0)
                pair_c[k] = {px_reg[k], 1'b0};
            else
                pair_c[k] = PAIR_W'(pend_rd[k]) + PAIR_W'(px_reg[k]);
        end
        xn_c    = (wl_reg == '0) ? '0 : (x_reg >> 1);
        idx_sum = (ADDR_W+1)'(row_base(lev_reg)) + (ADDR_W+1)'(xn_c);
        idx     = (idx_sum >= (ADDR_W+1)'(ROW_DEPTH)) ? ADDR_W'(ROW_DEPTH - 1)
                                                      : idx_sum[ADDR_W-1:0];
    end

    // Vertical total and the context of the next level
    always_comb
    begin
        total = '0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (hl_reg == '0)
                total = {pair_reg[k], 1'b0};
            else
                total = TOTAL_W'(rd_data_reg[k]) + TOTAL_W'(pair_reg[k]);
            px_new[k] = total[TOTAL_W-1:2];
        end
        y_new  = (hl_reg == '0) ? '0 : (y_reg >> 1);
        wl_new = (wl_reg == '0) ? '0 : wl_reg - 1'b1;
        hl_new = (hl_reg == '0) ? '0 : hl_reg - 1'b1;
        // No level left at all, or the level of this result is a single pixel
        run_end = (lev_reg == LEV_W'(LOG_MAX_SIZE - 1))
               || (wl_new == '0 && hl_new == '0);
        last    = run_end
               || (wl_new != '0 && !xn_reg[0])
               || (hl_new != '0 && !y_new[0]);
    end

    always_comb
    begin
        state_next = state_reg;
        lev_next   = lev_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        xn_next    = xn_reg;
        wl_next    = wl_reg;
        hl_next    = hl_reg;
        px_next    = px_reg;
        pair_next  = pair_reg;
        pend_we    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        done       = 1'b0;
        res_valid  = 1'b0;

        res.level = LOG_W'(lev_reg) + 1'b1;
        res.x     = xn_reg[OUT_COORD_W-1:0];
        res.y     = y_new[OUT_COORD_W-1:0];
        res.pix   = px_new;
        res.last  = last;

        case (state_reg)
            ST_IDLE:
            begin
                done = 1'b1;
            end
            ST_H:
            begin
                if (wl_reg != '0 && !x_reg[0])
                begin
                    pend_we = 1'b1;
                    done    = 1'b1;
                end
                else if (hl_reg != '0 && !y_reg[0])
                begin
                    mem_we = 1'b1;
                    done   = 1'b1;
                end
                else
                begin
                    mem_re     = (hl_reg != '0);
                    pair_next  = pair_c;
                    xn_next    = xn_c;
                    state_next = ST_V;
                end
            end
            ST_V:
            begin
                if (res_space)
                begin
                    res_valid = 1'b1;
                    lev_next  = lev_reg + 1'b1;
                    x_next    = xn_reg;
                    y_next    = y_new;
                    wl_next   = wl_new;
                    hl_next   = hl_new;
                    px_next   = px_new;
                    // A last result that leaves a half pair still visits the
                    // next level to park it
                    if (run_end)
                        done = 1'b1;
                    else
                        state_next = ST_H;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Start the next item in the cycle that finishes this one
        item_ready = done;
        load       = done && item_valid;
        if (done)
            state_next = ST_IDLE;
        if (load)
        begin
            lev_next   = '0;
            x_next     = item.x;
            y_next     = item.y;
            wl_next    = item.lw;
            hl_next    = item.lh;
            px_next    = item.pix;
            state_next = (item.en && (item.lw != '0 || item.lh != '0)) ? ST_H : ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        lev_reg  <= lev_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        xn_reg   <= xn_next;
        wl_reg   <= wl_next;
        hl_reg   <= hl_next;
        px_reg   <= px_next;
        pair_reg <= pair_next;
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[lev_reg] <= px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[idx] <= pair_c;
        if (mem_re)
            rd_data_reg <= row_mem[idx];
    end

endmodule

// ===== src/mipmap_box_filter_generator.sv =====
// A pixel passes the input buffer and the sequencer's H and V states before its result
// reaches the output register; each further level of the same pixel passes H and V again.
// A pixel with no result only parks in the sequencer, and one whose last result leaves a
// half pair also visits the next level down to park it. V waits on the row memory's
// registered read; the sequencer takes the next pixel only once it is done with the last.
// Reset clears counters, handshakes and registers (log sizes 0, mipmaps on);
// the memories need no clearing, since every entry is written before it is read.
`timescale 1ns / 1ps

module mipmap_box_filter_generator
(
    input  logic       clk,
    input  logic       rst_n,
    mbf_pix_if.sink    pix_in,
    mbf_res_if.source  res_out,
    mbf_cfg_if.sink    cfg
);
    import mbf_pkg::*;

    // Configuration registers
    logic [LOG_W-1:0]   lw_reg, lw_next;
    logic [LOG_W-1:0]   lh_reg, lh_next;
    logic               en_reg, en_next;

    // Raster position of the next base pixel
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;

    // Input buffer between the channel and the sequencer
    logic               buf_valid_reg, buf_valid_next;
    item_t              buf_reg, buf_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               in_xfer, cfg_xfer;
    logic               eng_ready, res_valid, res_space;
    result_t            res;
    logic [LOG_W-1:0]   lw_c, lh_c;
    logic               row_end, image_end;

    mbf_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (buf_valid_reg),
        .item       (buf_reg),
        .item_ready (eng_ready),
        .res_space  (res_space),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign cfg.ready    = 1'b1;
    assign cfg_xfer     = cfg.valid && cfg.ready;
    // Refill the buffer in the same cycle the sequencer drains it
    assign pix_in.ready = !buf_valid_reg || eng_ready;
    assign in_xfer      = pix_in.valid && pix_in.ready;
    assign res_space    = !out_valid_reg || res_out.ready;

    assign lw_c      = clamp_log(lw_reg);
    assign lh_c      = clamp_log(lh_reg);
    assign row_end   = ((COORD_W+1)'(col_reg) + 1'b1) >= ((COORD_W+1)'(1) << lw_c);
    assign image_end = ((COORD_W+1)'(row_reg) + 1'b1) >= ((COORD_W+1)'(1) << lh_c);

    always_comb
    begin
        lw_next        = lw_reg;
        lh_next        = lh_reg;
        en_next        = en_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        buf_valid_next = buf_valid_reg;
        buf_next       = buf_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // A write to a known register also restarts the image
        if (cfg_xfer)
        begin
            case (cfg.index)
                CFG_LOG_WIDTH:
                begin
                    lw_next  = cfg.data;
                    col_next = '0;
                    row_next = '0;
                end
                CFG_LOG_HEIGHT:
                begin
                    lh_next  = cfg.data;
                    col_next = '0;
                    row_next = '0;
                end
                CFG_MIPMAP_ENABLE:
                begin
                    en_next  = cfg.data[0];
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                    lw_next = lw_reg;
                end
            endcase
        end

        // Drop the buffered item once the sequencer takes it
        if (buf_valid_reg && eng_ready)
            buf_valid_next = 1'b0;

        // Tag each pixel with its position and advance the raster counters
        if (in_xfer)
        begin
            buf_valid_next = 1'b1;
            buf_next.pix   = {pix_in.alpha, pix_in.blue, pix_in.green, pix_in.red};
            buf_next.x     = col_reg;
            buf_next.y     = row_reg;
            buf_next.lw    = lw_c;
            buf_next.lh    = lh_c;
            buf_next.en    = en_reg;
            if (row_end)
            begin
                col_next = '0;
                row_next = image_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        // Hold the result until its transfer
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg        <= '0;
            lh_reg        <= '0;
            en_reg        <= 1'b1;
            col_reg       <= '0;
            row_reg       <= '0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lw_reg        <= lw_next;
            lh_reg        <= lh_next;
            en_reg        <= en_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        out_reg <= out_next;
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.level       = out_reg.level;
    assign res_out.out_x       = out_reg.x;
    assign res_out.out_y       = out_reg.y;
    assign res_out.out_red     = out_reg.pix[0];
    assign res_out.out_green   = out_reg.pix[1];
    assign res_out.out_blue    = out_reg.pix[2];
    assign res_out.out_alpha   = out_reg.pix[3];
    assign res_out.last_of_run = out_reg.last;

endmodule
